FILE: hw/rtl/bitmap_page_allocator_macros.svh
// Assertion macros shared by the page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BPA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bpa_pkg.sv
// Types and constants of the bitmap page allocator.
package bpa_pkg;

  // Map word: pages covered by one memory entry
  localparam int WORD_BITS = 64;
  localparam int WORD_LW   = 6;

  // Pages covered by the used map
  localparam int PAGES = 65536;

  // Field widths
  localparam int OP_W    = 2;
  localparam int PAGE_W  = 16;
  localparam int CNT_W   = 9;
  localparam int LIMIT_W = 17;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

  // Request word
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
  } req_t;

  // Response word
  typedef struct packed {
    logic [PAGE_W-1:0]  first_page;
    logic               ok;
    logic [LIMIT_W-1:0] used_pages;
  } rsp_t;

  // Per-word run search result
  typedef struct packed {
    logic               hit;
    logic [WORD_LW-1:0] pos;
    logic [CNT_W-1:0]   run_out;
  } run_res_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PASS,
    ST_SCAN,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RESP
  } state_t;

endpackage

FILE: hw/rtl/bpa_map.sv
// Used-page map memory: one word of pages per entry, fill-to-used sweep after reset.
module bpa_map #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [bpa_pkg::WORD_BITS-1:0]  rd_data,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [bpa_pkg::WORD_BITS-1:0]  wr_data,
  output logic                           ready
);

  logic [bpa_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic                          filling;
  logic [AW-1:0]                 fill_addr;

  // Sweep every entry to all-used after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
    end else if (filling) begin
      if (fill_addr == AW'(DEPTH - 1)) begin
        filling <= 1'b0;
      end else begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  // Single write port, shared by the sweep and the sequencer
  always_ff @(posedge clk) begin
    if (filling) begin
      mem[fill_addr] <= '1;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !filling;

endmodule

FILE: hw/rtl/bpa_run_find.sv
// Finds the first page in one map word where a free run reaches the request count.
module bpa_run_find (
  input  logic [bpa_pkg::WORD_BITS-1:0] word_used,
  input  logic [bpa_pkg::WORD_BITS-1:0] word_mask,
  input  logic [bpa_pkg::CNT_W-1:0]     run_in,
  input  logic [bpa_pkg::CNT_W-1:0]     cnt,
  output bpa_pkg::run_res_t             res
);

  localparam int W  = bpa_pkg::WORD_BITS;
  localparam int LW = bpa_pkg::WORD_LW;
  localparam int CW = bpa_pkg::CNT_W;

  logic [W-1:0]  used_eff;
  logic [LW:0]   last_used [LW+1][W];
  logic [CW:0]   run_len [W];
  logic [W-1:0]  hit;

  // Pages outside the search window count as used
  assign used_eff = word_used | ~word_mask;

  // Prefix scan: last used position (plus one) at or below each bit, zero if none
  always_comb begin
    for (int j = 0; j < W; j++) begin
      last_used[0][j] = used_eff[j] ? (LW+1)'(j + 1) : '0;
    end
    for (int k = 0; k < LW; k++) begin
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << k) && last_used[k][j] == '0) begin
          last_used[k+1][j] = last_used[k][j - (1 << k)];
        end else begin
          last_used[k+1][j] = last_used[k][j];
        end
      end
    end
  end

  // Free run length ending at each bit, carrying the run from earlier words
  always_comb begin
    for (int j = 0; j < W; j++) begin
      if (last_used[LW][j] == '0) begin
        run_len[j] = {1'b0, run_in} + (CW+1)'(j + 1);
      end else begin
        run_len[j] = (CW+1)'(j + 1) - (CW+1)'(last_used[LW][j]);
      end
      hit[j] = (run_len[j] >= {1'b0, cnt});
    end
  end

  // Lowest bit where the run is long enough
  always_comb begin
    res.hit     = |hit;
    res.pos     = '0;
    res.run_out = run_len[W-1][CW-1:0];
    for (int j = W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        res.pos = LW'(j);
      end
    end
  end

endmodule

FILE: hw/rtl/bitmap_page_allocator.sv
// Next-fit bitmap page allocator top level: sequencer, counters and output register.
// The used map lives in a one-port-read, one-port-write memory of 64-page words and
// resets to all used through a fill sweep over all ceil(PAGES/64) words (1024 for the
// 64K-page map) during which no request is taken. One request is worked at a time. Free
// and mark-free read and write back each map word the range touches (at most five words
// for 256 pages). An allocation reads one map word per cycle: first the words between
// the roving index and the limit, then, if that pass fails, the words from page 0 to the
// old roving index, then it reads and writes back each word that it marks.
// The result sits in an output register, so a new request is taken while it waits.
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator #(
  parameter int MAX_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bpa_pkg::req_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bpa_pkg::rsp_t                out_data,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int PAGES = bpa_pkg::PAGES;
  localparam int W   = bpa_pkg::WORD_BITS;
  localparam int LW  = bpa_pkg::WORD_LW;
  localparam int PW  = bpa_pkg::LIMIT_W;
  localparam int NC  = bpa_pkg::CNT_W;
  localparam int SW  = PW - LW;
  localparam int NW  = (PAGES + W - 1) / W;
  localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW  = $clog2(PAGES + 1);

  bpa_pkg::state_t state, state_next;

  logic [bpa_pkg::OP_W-1:0]   cur_op, cur_op_next;
  logic [NC-1:0]              cnt, cnt_next;
  logic                       pass2, pass2_next;
  logic [PW-1:0]              pass_start, pass_start_next;
  logic [PW-1:0]              pass_end, pass_end_next;
  logic [SW:0]                rd_word, rd_word_next;
  logic [SW-1:0]              last_word, last_word_next;
  logic [SW-1:0]              proc_word, proc_word_next;
  logic                       pend, pend_next;
  logic [NC-1:0]              run, run_next;
  logic [PW-1:0]              rng_lo, rng_lo_next;
  logic [PW-1:0]              rng_hi, rng_hi_next;
  logic [SW-1:0]              rng_word, rng_word_next;
  logic [SW-1:0]              rng_last, rng_last_next;
  logic                       rng_set, rng_set_next;
  logic [bpa_pkg::PAGE_W-1:0] res_first, res_first_next;
  logic                       res_ok, res_ok_next;
  logic [PW-1:0]              rover, rover_next;
  logic [CW-1:0]              used_count, used_count_next;
  logic [PW-1:0]              limit;
  logic                       out_load;
  logic                       finish;

  logic                       map_rd_en;
  logic [AW-1:0]              map_rd_addr;
  logic [W-1:0]               map_rd_data;
  logic                       map_wr_en;
  logic [AW-1:0]              map_wr_addr;
  logic [W-1:0]               map_wr_data;
  logic                       map_ready;

  logic [W-1:0]               scan_mask;
  logic [W-1:0]               wr_mask;
  bpa_pkg::run_res_t          rf;

  logic                       req_ok;
  logic [PW-1:0]              lim_eff;
  logic [PW-1:0]              req_hi;
  logic [PW-1:0]              hit_end;
  logic [PW-1:0]              hit_first;
  logic [31:0]                used_sum;

  // Map memory
  bpa_map #(
    .DEPTH (NW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .ready   (map_ready)
  );

  // Run search over the word in flight
  bpa_run_find u_find (
    .word_used (map_rd_data),
    .word_mask (scan_mask),
    .run_in    (run),
    .cnt       (cnt),
    .res       (rf)
  );

  // Window masks: search pass window and read-modify-write range
  always_comb begin
    for (int j = 0; j < W; j++) begin
      scan_mask[j] = ({proc_word, LW'(j)} >= pass_start) && ({proc_word, LW'(j)} < pass_end);
      wr_mask[j]   = ({rng_word, LW'(j)} >= rng_lo) && ({rng_word, LW'(j)} < rng_hi);
    end
  end

  // Request decode helpers
  assign req_ok = (in_data.count != '0) && ({23'b0, in_data.count} <= 32'(MAX_COUNT)) &&
                  (in_data.op inside {bpa_pkg::OP_ALLOC, bpa_pkg::OP_FREE, bpa_pkg::OP_MARK});
  assign lim_eff   = (32'(limit) > 32'(PAGES)) ? PW'(PAGES) : limit;
  assign req_hi    = {1'b0, in_data.page} + PW'(in_data.count);
  assign hit_end   = {proc_word, rf.pos} + PW'(1);
  assign hit_first = hit_end - PW'(cnt);
  assign used_sum  = 32'(used_count) + 32'(cnt);

  // Sequencer
  always_comb begin
    state_next      = state;
    cur_op_next     = cur_op;
    cnt_next        = cnt;
    pass2_next      = pass2;
    pass_start_next = pass_start;
    pass_end_next   = pass_end;
    rd_word_next    = rd_word;
    last_word_next  = last_word;
    proc_word_next  = proc_word;
    pend_next       = 1'b0;
    run_next        = run;
    rng_lo_next     = rng_lo;
    rng_hi_next     = rng_hi;
    rng_word_next   = rng_word;
    rng_last_next   = rng_last;
    rng_set_next    = rng_set;
    res_first_next  = res_first;
    res_ok_next     = res_ok;
    rover_next      = rover;
    used_count_next = used_count;
    map_rd_en       = 1'b0;
    map_rd_addr     = '0;
    map_wr_en       = 1'b0;
    map_wr_addr     = '0;
    map_wr_data     = '0;
    in_ready        = 1'b0;
    out_load        = 1'b0;
    finish          = 1'b0;

    case (state)
      bpa_pkg::ST_INIT: begin
        if (map_ready) begin
          state_next = bpa_pkg::ST_IDLE;
        end
      end

      bpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_op_next = in_data.op;
          cnt_next    = in_data.count;
          if (!req_ok) begin
            res_first_next = '0;
            res_ok_next    = 1'b0;
            state_next     = bpa_pkg::ST_RESP;
          end else if (in_data.op == bpa_pkg::OP_ALLOC) begin
            pass2_next      = 1'b0;
            pass_start_next = rover;
            pass_end_next   = lim_eff;
            state_next      = bpa_pkg::ST_PASS;
          end else begin
            rng_lo_next   = {1'b0, in_data.page};
            rng_hi_next   = req_hi;
            rng_word_next = SW'({1'b0, in_data.page} >> LW);
            rng_last_next = SW'((req_hi - PW'(1)) >> LW);
            rng_set_next  = 1'b0;
            state_next    = bpa_pkg::ST_RMW_RD;
          end
        end
      end

      // Set up one search pass, or fall through when its window is empty
      bpa_pkg::ST_PASS: begin
        if (pass_start >= pass_end) begin
          if (!pass2) begin
            pass2_next      = 1'b1;
            pass_start_next = '0;
            pass_end_next   = rover;
          end else begin
            res_first_next = '0;
            res_ok_next    = 1'b0;
            state_next     = bpa_pkg::ST_RESP;
          end
        end else begin
          rd_word_next   = (SW+1)'(pass_start >> LW);
          last_word_next = SW'((pass_end - PW'(1)) >> LW);
          run_next       = '0;
          state_next     = bpa_pkg::ST_SCAN;
        end
      end

      // One word read per cycle, evaluated the cycle after
      bpa_pkg::ST_SCAN: begin
        if (rd_word <= {1'b0, last_word}) begin
          map_rd_en      = 1'b1;
          map_rd_addr    = AW'(rd_word[SW-1:0]);
          rd_word_next   = rd_word + 1'b1;
          pend_next      = 1'b1;
          proc_word_next = rd_word[SW-1:0];
        end
        if (pend) begin
          if (rf.hit) begin
            rng_lo_next    = hit_first;
            rng_hi_next    = hit_end;
            rng_word_next  = SW'(hit_first >> LW);
            rng_last_next  = proc_word;
            rng_set_next   = 1'b1;
            res_first_next = hit_first[bpa_pkg::PAGE_W-1:0];
            rover_next     = hit_end;
            pend_next      = 1'b0;
            state_next     = bpa_pkg::ST_RMW_RD;
          end else begin
            run_next = rf.run_out;
            if (proc_word == last_word) begin
              pend_next = 1'b0;
              if (!pass2) begin
                pass2_next      = 1'b1;
                pass_start_next = '0;
                pass_end_next   = rover;
                state_next      = bpa_pkg::ST_PASS;
              end else begin
                res_first_next = '0;
                res_ok_next    = 1'b0;
                state_next     = bpa_pkg::ST_RESP;
              end
            end
          end
        end
      end

      // Range update: read a word, or stop past the end of the map
      bpa_pkg::ST_RMW_RD: begin
        if (32'(rng_word) >= 32'(NW)) begin
          finish = 1'b1;
        end else begin
          map_rd_en   = 1'b1;
          map_rd_addr = AW'(rng_word);
          state_next  = bpa_pkg::ST_RMW_WR;
        end
      end

      bpa_pkg::ST_RMW_WR: begin
        map_wr_en   = 1'b1;
        map_wr_addr = AW'(rng_word);
        map_wr_data = rng_set ? (map_rd_data | wr_mask) : (map_rd_data & ~wr_mask);
        if (rng_word == rng_last) begin
          finish = 1'b1;
        end else begin
          rng_word_next = rng_word + 1'b1;
          state_next    = bpa_pkg::ST_RMW_RD;
        end
      end

      bpa_pkg::ST_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = bpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bpa_pkg::ST_IDLE;
      end
    endcase

    // Accounting once the range update is done
    if (finish) begin
      res_ok_next = 1'b1;
      state_next  = bpa_pkg::ST_RESP;
      case (cur_op)
        bpa_pkg::OP_ALLOC: begin
          used_count_next = (used_sum > 32'(PAGES)) ? CW'(PAGES) : CW'(used_sum);
        end
        bpa_pkg::OP_FREE: begin
          res_first_next  = '0;
          used_count_next = (32'(used_count) > 32'(cnt)) ?
                            CW'(32'(used_count) - 32'(cnt)) : '0;
        end
        default: begin
          res_first_next = '0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpa_pkg::ST_INIT;
      pend       <= 1'b0;
      rover      <= '0;
      used_count <= '0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      rover      <= rover_next;
      used_count <= used_count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur_op     <= cur_op_next;
    cnt        <= cnt_next;
    pass2      <= pass2_next;
    pass_start <= pass_start_next;
    pass_end   <= pass_end_next;
    rd_word    <= rd_word_next;
    last_word  <= last_word_next;
    proc_word  <= proc_word_next;
    run        <= run_next;
    rng_lo     <= rng_lo_next;
    rng_hi     <= rng_hi_next;
    rng_word   <= rng_word_next;
    rng_last   <= rng_last_next;
    rng_set    <= rng_set_next;
    res_first  <= res_first_next;
    res_ok     <= res_ok_next;
  end

  // Page limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= PW'(65536);
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.first_page <= res_first;
      out_data.ok         <= res_ok;
      out_data.used_pages <= PW'(used_count);
    end
  end

  // Checks
  `BPA_ASSERT_ALWAYS(a_used_bound, clk, rst, 32'(used_count) <= 32'(PAGES), "used count above page total")
  `BPA_ASSERT_ALWAYS(a_rover_bound, clk, rst, 32'(rover) <= 32'(PAGES), "roving index past the map")
  `BPA_ASSERT_IMPL(a_scan_no_write, clk, rst, state == bpa_pkg::ST_SCAN, !map_wr_en, "map write during scan")
  `BPA_ASSERT_IMPL(a_rover_after_hit, clk, rst, !$past(rst) && !$stable(rover), $past(state == bpa_pkg::ST_SCAN), "roving index moved outside a scan hit")

endmodule
